// ===== rtl/yuvrgb_pkg.sv =====
package yuvrgb_pkg;

	localparam int FRAC_BITS = 15;

	// conversion weights, scaled by 2^15
	localparam logic signed [25:0] COEF_RV = 26'sd37221;
	localparam logic signed [25:0] COEF_GU = 26'sd12975;
	localparam logic signed [25:0] COEF_GV = 26'sd18949;
	localparam logic signed [25:0] COEF_BU = 26'sd66883;

	// byte order codes
	localparam logic ORDER_YUYV = 1'b0;
	localparam logic ORDER_UYVY = 1'b1;

	typedef logic signed [7:0]  chroma_t;	// chroma with the 128 offset removed
	typedef logic signed [25:0] prod_t;
	typedef logic signed [9:0]  delta_t;	// floored chroma contribution
	typedef logic signed [10:0] sum_t;		// luma plus contribution, before clamping

	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic       last_in;
	} in_t;

	typedef struct packed {
		logic [7:0] red0;
		logic [7:0] green0;
		logic [7:0] blue0;
		logic [7:0] red1;
		logic [7:0] green1;
		logic [7:0] blue1;
		logic       last_out;
	} out_t;

	typedef struct packed {
		delta_t dr;
		delta_t dg;
		delta_t db;
	} delta_set_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	function automatic logic [7:0] sat8(input sum_t s);
		logic [7:0] r;
		if (s < 0) begin
			r = 8'd0;
		end else if (s > 11'sd255) begin
			r = 8'd255;
		end else begin
			r = s[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/yuvrgb_chroma.sv =====
module yuvrgb_chroma (
	input  yuvrgb_pkg::chroma_t    u,
	input  yuvrgb_pkg::chroma_t    v,
	output yuvrgb_pkg::delta_set_t deltas
);

	yuvrgb_pkg::prod_t prod_rv;
	yuvrgb_pkg::prod_t prod_g;
	yuvrgb_pkg::prod_t prod_bu;
	yuvrgb_pkg::prod_t shr_rv;
	yuvrgb_pkg::prod_t shr_g;
	yuvrgb_pkg::prod_t shr_bu;

	// constant multiplies, shared by both lumas
	assign prod_rv = yuvrgb_pkg::prod_t'(v) * yuvrgb_pkg::COEF_RV;
	assign prod_g  = yuvrgb_pkg::prod_t'(u) * yuvrgb_pkg::COEF_GU
		+ yuvrgb_pkg::prod_t'(v) * yuvrgb_pkg::COEF_GV;
	assign prod_bu = yuvrgb_pkg::prod_t'(u) * yuvrgb_pkg::COEF_BU;

	// arithmetic shift floors toward minus infinity
	assign shr_rv = prod_rv >>> yuvrgb_pkg::FRAC_BITS;
	assign shr_g  = prod_g  >>> yuvrgb_pkg::FRAC_BITS;
	assign shr_bu = prod_bu >>> yuvrgb_pkg::FRAC_BITS;

	assign deltas.dr = shr_rv[9:0];
	assign deltas.dg = shr_g[9:0];
	assign deltas.db = shr_bu[9:0];

endmodule

// ===== rtl/yuvrgb_pixel.sv =====
module yuvrgb_pixel (
	input  logic [7:0]             y,
	input  yuvrgb_pkg::delta_set_t deltas,
	output yuvrgb_pkg::pixel_t     pixel
);

	yuvrgb_pkg::sum_t y_ext;
	yuvrgb_pkg::sum_t sum_r;
	yuvrgb_pkg::sum_t sum_g;
	yuvrgb_pkg::sum_t sum_b;

	assign y_ext = $signed({3'b000, y});
	assign sum_r = y_ext + yuvrgb_pkg::sum_t'(deltas.dr);
	assign sum_g = y_ext - yuvrgb_pkg::sum_t'(deltas.dg);
	assign sum_b = y_ext + yuvrgb_pkg::sum_t'(deltas.db);

	assign pixel.red   = yuvrgb_pkg::sat8(sum_r);
	assign pixel.green = yuvrgb_pkg::sat8(sum_g);
	assign pixel.blue  = yuvrgb_pkg::sat8(sum_b);

endmodule

// ===== rtl/yuv422_fixed_to_rgb888.sv =====
// packed 4:2:2 yuv to rgb888 converter
// input channel: in_valid / in_ready carry one macropixel of four bytes and a
//   last flag per transaction; output channel: out_valid / out_ready carry two
//   rgb888 pixels and the copied last flag per transaction
// cfg_wr_en / cfg_wr_data write the byte order register (0 = yuyv, 1 = uyvy),
//   taken at the edge where cfg_wr_en is high; only to be written while idle
// path: an accepted transaction sits in the input register, then moves into the
//   result register, which drives out_data
// throughput: one macropixel per cycle while out_ready is high, set by the single pass of
//   constant multiplies and clamps between the input register and the result register
// when the receiver stalls the result register holds its data, the input
//   register still takes one more transaction, and in_ready drops only once
//   both registers are full; no transaction is lost or repeated
// reset clears both valid flags and sets the byte order to yuyv; payload
//   registers are not reset
module yuv422_fixed_to_rgb888 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  yuvrgb_pkg::in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output yuvrgb_pkg::out_t out_data,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data
);

	// configuration
	logic byte_order_q;

	// stage 1: unpacked luma and offset-free chroma
	logic                valid_s1;
	logic [7:0]          y0_s1;
	logic [7:0]          y1_s1;
	yuvrgb_pkg::chroma_t u_s1;
	yuvrgb_pkg::chroma_t v_s1;
	logic                last_s1;

	// stage 2: result register
	logic             valid_s2;
	yuvrgb_pkg::out_t out_s2;

	logic adv_s1;
	logic adv_s2;

	logic [7:0] y0_in;
	logic [7:0] y1_in;
	logic [7:0] u_raw;
	logic [7:0] v_raw;

	yuvrgb_pkg::delta_set_t deltas;
	yuvrgb_pkg::pixel_t     pix0;
	yuvrgb_pkg::pixel_t     pix1;

	// result register moves when empty or drained; input register follows
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= yuvrgb_pkg::ORDER_YUYV;
		end else if (cfg_wr_en) begin
			byte_order_q <= cfg_wr_data;
		end
	end

	// byte order selection at the input
	always_comb begin
		unique case (byte_order_q)
			yuvrgb_pkg::ORDER_YUYV: begin
				y0_in = in_data.byte0;
				u_raw = in_data.byte1;
				y1_in = in_data.byte2;
				v_raw = in_data.byte3;
			end
			yuvrgb_pkg::ORDER_UYVY: begin
				u_raw = in_data.byte0;
				y0_in = in_data.byte1;
				v_raw = in_data.byte2;
				y1_in = in_data.byte3;
			end
			default: begin
				y0_in = in_data.byte0;
				u_raw = in_data.byte1;
				y1_in = in_data.byte2;
				v_raw = in_data.byte3;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// removing the 128 offset is just an msb flip
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			y0_s1   <= y0_in;
			y1_s1   <= y1_in;
			u_s1    <= $signed({~u_raw[7], u_raw[6:0]});
			v_s1    <= $signed({~v_raw[7], v_raw[6:0]});
			last_s1 <= in_data.last_in;
		end
	end

	// chroma contributions are shared by both pixels
	yuvrgb_chroma u_chroma (
		.u      (u_s1),
		.v      (v_s1),
		.deltas (deltas)
	);

	yuvrgb_pixel u_pixel0 (
		.y      (y0_s1),
		.deltas (deltas),
		.pixel  (pix0)
	);

	yuvrgb_pixel u_pixel1 (
		.y      (y1_s1),
		.deltas (deltas),
		.pixel  (pix1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			out_s2.red0     <= pix0.red;
			out_s2.green0   <= pix0.green;
			out_s2.blue0    <= pix0.blue;
			out_s2.red1     <= pix1.red;
			out_s2.green1   <= pix1.green;
			out_s2.blue1    <= pix1.blue;
			out_s2.last_out <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

	// input side only stalls with both registers full and the receiver stalled
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("in_ready low without a full, stalled pipeline");

	// a stage 1 transaction moving on shows up as a valid result
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> out_valid)
		else $error("stage 1 transaction lost on the way to the output");

	// the last flag travels with its macropixel
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> (out_data.last_out == $past(last_s1)))
		else $error("last flag not carried with its transaction");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// checks the 4:2:2 macropixel to rgb888 converter against a predictor kept in
// this file; a short directed set in each byte order, then a long random
// stream with idle gaps and back-pressure switched on and off by phase
module tb;

	// conversion weights, scaled by 2^15
	localparam int RV_WEIGHT   = 37221;
	localparam int GU_WEIGHT   = 12975;
	localparam int GV_WEIGHT   = 18949;
	localparam int BU_WEIGHT   = 66883;
	localparam int CHROMA_MID  = 128;
	localparam int WEIGHT_BITS = 15;

	// cycles with no transaction on either channel before giving up
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	yuvrgb_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	yuvrgb_pkg::out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	// our copy of the byte order register
	logic order_shadow = yuvrgb_pkg::ORDER_YUYV;
	// when clear, both sides run without gaps or stalls
	bit   idling_on = 1'b1;

	yuvrgb_pkg::out_t rgb_pending[$];
	int   mismatch_count = 0;
	int   result_count = 0;
	int   quiet_cycles = 0;

	yuv422_fixed_to_rgb888 i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// saturate an intermediate channel value to a byte
	function automatic logic [7:0] clamp_channel(int v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	// two rgb pixels from one macropixel; >>> on a signed int floors
	function automatic yuvrgb_pkg::out_t predict_rgb(yuvrgb_pkg::in_t px, logic order);
		int   luma0, luma1, cb, cr, dr, dg, db;
		yuvrgb_pkg::out_t res;
		if (order == yuvrgb_pkg::ORDER_YUYV) begin
			luma0 = px.byte0;
			cb    = px.byte1;
			luma1 = px.byte2;
			cr    = px.byte3;
		end else begin
			cb    = px.byte0;
			luma0 = px.byte1;
			cr    = px.byte2;
			luma1 = px.byte3;
		end
		cb = cb - CHROMA_MID;
		cr = cr - CHROMA_MID;
		dr = (cr * RV_WEIGHT) >>> WEIGHT_BITS;
		dg = (cb * GU_WEIGHT + cr * GV_WEIGHT) >>> WEIGHT_BITS;
		db = (cb * BU_WEIGHT) >>> WEIGHT_BITS;
		res.red0     = clamp_channel(luma0 + dr);
		res.green0   = clamp_channel(luma0 - dg);
		res.blue0    = clamp_channel(luma0 + db);
		res.red1     = clamp_channel(luma1 + dr);
		res.green1   = clamp_channel(luma1 - dg);
		res.blue1    = clamp_channel(luma1 + db);
		res.last_out = px.last_in;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t, result %0d: %s", $realtime, result_count, msg);
		mismatch_count++;
	endtask

	task automatic check_channel(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// both channels sampled at the rising edge; the expectation is queued at
	// input acceptance with the byte order in force at that moment
	always @(posedge clk) begin
		yuvrgb_pkg::out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				rgb_pending.push_back(predict_rgb(in_data, order_shadow));
			end
			if (out_valid && out_ready) begin
				if (rgb_pending.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = rgb_pending.pop_front();
					check_channel("red0", out_data.red0, want.red0);
					check_channel("green0", out_data.green0, want.green0);
					check_channel("blue0", out_data.blue0, want.blue0);
					check_channel("red1", out_data.red1, want.red1);
					check_channel("green1", out_data.green1, want.green1);
					check_channel("blue1", out_data.blue1, want.blue1);
					if (out_data.last_out !== want.last_out) begin
						report_mismatch("last_out differs");
					end
				end
				result_count++;
			end
		end
	end

	// watchdog: any transaction on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver: draws a stall for each result, then holds ready until it is taken
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = idling_on ? $urandom_range(0, 9) : 0;
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one macropixel: optional gap with valid low, then valid held until taken
	task automatic send_macropixel(yuvrgb_pkg::in_t px);
		int gap;
		gap = idling_on ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = px;
		do @(posedge clk); while (!in_ready);
	endtask

	// sender goes quiet until every outstanding result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (rgb_pending.size() != 0) @(negedge clk);
	endtask

	// register writes only happen with the pipeline empty
	task automatic set_byte_order(logic order);
		wait_drained();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = order;
		@(negedge clk);
		cfg_wr_en    = 1'b0;
		order_shadow = order;
	endtask

	function automatic yuvrgb_pkg::in_t make_px(int b0, int b1, int b2, int b3, bit last);
		yuvrgb_pkg::in_t px;
		px.byte0   = b0[7:0];
		px.byte1   = b1[7:0];
		px.byte2   = b2[7:0];
		px.byte3   = b3[7:0];
		px.last_in = last;
		return px;
	endfunction

	// bias towards the rails and neutral chroma, otherwise uniform
	function automatic int pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 0;
			end
			1: begin
				return 255;
			end
			2: begin
				return $urandom_range(124, 132);
			end
			default: begin
				return $urandom_range(0, 255);
			end
		endcase
	endfunction

	// yuyv after reset: black, white, chroma at both rails, luma at both rails
	task automatic test_yuyv_extremes();
		send_macropixel(make_px(0, 0, 0, 0, 1'b0));
		send_macropixel(make_px(255, 255, 255, 255, 1'b1));
		send_macropixel(make_px(0, 0, 0, 255, 1'b0));
		send_macropixel(make_px(255, 255, 255, 0, 1'b0));
		send_macropixel(make_px(0, 128, 255, 128, 1'b1));
		send_macropixel(make_px(255, 0, 0, 255, 1'b0));
		send_macropixel(make_px(0, 255, 255, 0, 1'b0));
		send_macropixel(make_px(16, 127, 235, 129, 1'b0));
		send_macropixel(make_px(128, 255, 128, 255, 1'b1));
		send_macropixel(make_px(170, 85, 85, 170, 1'b0));
		send_macropixel(make_px(85, 170, 170, 85, 1'b1));
	endtask

	// same corners with the chroma bytes in the other positions
	task automatic test_uyvy_extremes();
		set_byte_order(yuvrgb_pkg::ORDER_UYVY);
		send_macropixel(make_px(0, 0, 0, 0, 1'b1));
		send_macropixel(make_px(255, 255, 255, 255, 1'b0));
		send_macropixel(make_px(0, 0, 255, 0, 1'b0));
		send_macropixel(make_px(255, 255, 0, 255, 1'b1));
		send_macropixel(make_px(128, 0, 128, 255, 1'b0));
		send_macropixel(make_px(255, 0, 0, 255, 1'b0));
		send_macropixel(make_px(0, 255, 255, 0, 1'b1));
		send_macropixel(make_px(127, 16, 129, 235, 1'b0));
		send_macropixel(make_px(85, 170, 170, 85, 1'b0));
		send_macropixel(make_px(170, 85, 85, 170, 1'b1));
	endtask

	// random stream in phases; each phase picks a byte order and whether the
	// two sides idle, and one phase stops halfway until the pipe is empty
	task automatic test_random_stream();
		int   n;
		int   len;
		int   pause_at;
		logic order;
		for (int phase = 0; phase < 8; phase++) begin
			// both orders early on, random after that
			order = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
			if (order != order_shadow) begin
				set_byte_order(order);
			end
			idling_on = (phase % 3) != 2;
			len       = $urandom_range(180, 220);
			pause_at  = (phase == 4) ? len / 2 : -1;
			for (n = 0; n < len; n++) begin
				if (n == pause_at) begin
					wait_drained();
				end
				send_macropixel(make_px(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
					$urandom_range(0, 7) == 0));
			end
		end
		idling_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_yuyv_extremes();
		test_uyvy_extremes();
		set_byte_order(yuvrgb_pkg::ORDER_YUYV);
		test_random_stream();

		// let the last transaction settle before the verdict
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && rgb_pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/yuvrgb_pkg.sv
rtl/yuvrgb_chroma.sv
rtl/yuvrgb_pixel.sv
rtl/yuv422_fixed_to_rgb888.sv
test/tb.sv
